FILE: rtl/mep_pkg.sv
package mep_pkg;

  // Field widths
  localparam int unsigned XW     = 11;
  localparam int unsigned YW     = 10;
  localparam int unsigned QW     = 32;   // Q3.28 word
  localparam int unsigned QFRAC  = 28;
  localparam int unsigned COLW   = 24;
  localparam int unsigned ITW    = 12;
  localparam int unsigned CFGIW  = 3;
  localparam int unsigned CFGDW  = 32;

  // Coordinate mapping: |idx * (hi - lo)| < 2^43
  localparam int unsigned MAGW   = 43;
  // Common width for sums ahead of Q3.28 saturation
  localparam int unsigned SUMW   = 45;
  localparam int unsigned PRODW  = 2 * QW;

  // 4.0 in Q7.56
  localparam logic [PRODW-1:0] FOUR_Q56 = 64'h0400_0000_0000_0000;

  // Reset values of the configuration registers
  localparam logic signed [QW-1:0] LEFT_RST   = -32'sd536870912;
  localparam logic signed [QW-1:0] RIGHT_RST  = 32'sd268435456;
  localparam logic signed [QW-1:0] TOP_RST    = 32'sd301989888;
  localparam logic signed [QW-1:0] BOTTOM_RST = -32'sd301989888;
  localparam logic [COLW-1:0]      COLOUR_RST = 24'hFF_FFFF;
  localparam logic [ITW-1:0]       LIMIT_RST  = 12'd500;

  typedef enum logic [CFGIW-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_BOTTOM = 3'd3,
    CFG_COLOUR = 3'd4,
    CFG_LIMIT  = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [XW-1:0] pixel_x;
    logic [YW-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [XW-1:0]   out_x;
    logic [YW-1:0]   out_y;
    logic [COLW-1:0] pixel_colour;
    logic [ITW-1:0]  iteration_count;
  } pixel_out_t;

  typedef struct packed {
    logic signed [QW-1:0] left_edge;
    logic signed [QW-1:0] right_edge;
    logic signed [QW-1:0] top_edge;
    logic signed [QW-1:0] bottom_edge;
    logic [COLW-1:0]      member_colour;
    logic [ITW-1:0]       iteration_limit;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_pixel;
    logic coord_sel;   // 0: real axis, 1: imaginary axis
    logic map_load;
    logic div_step;
    logic map_store;
    logic mul;
    logic update;
    logic out_load;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_last;
    logic iter_done;
  } dp_status_t;

  // Clamp to the Q3.28 range
  function automatic logic signed [QW-1:0] sat_q(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi_lim;
    logic signed [SUMW-1:0] lo_lim;
    hi_lim = SUMW'(32'sh7FFF_FFFF);
    lo_lim = SUMW'(32'sh8000_0000);
    if (v > hi_lim) begin
      return hi_lim[QW-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[QW-1:0];
    end else begin
      return v[QW-1:0];
    end
  endfunction

endpackage

FILE: rtl/mep_ctrl.sv
module mep_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mep_pkg::dp_cmd_t     cmd_o,
  input  mep_pkg::dp_status_t  status_i
);
  import mep_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_MAP_X = 10'b00_0000_0010,
    ST_DIV_X = 10'b00_0000_0100,
    ST_FIN_X = 10'b00_0000_1000,
    ST_MAP_Y = 10'b00_0001_0000,
    ST_DIV_Y = 10'b00_0010_0000,
    ST_FIN_Y = 10'b00_0100_0000,
    ST_MUL   = 10'b00_1000_0000,
    ST_UPD   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_pixel = 1'b1;
          state_d          = ST_MAP_X;
        end
      end
      ST_MAP_X: begin
        cmd_o.map_load = 1'b1;
        state_d        = ST_DIV_X;
      end
      ST_DIV_X: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN_X;
        end
      end
      ST_FIN_X: begin
        cmd_o.map_store = 1'b1;
        state_d         = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        cmd_o.coord_sel = 1'b1;
        cmd_o.map_load  = 1'b1;
        state_d         = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd_o.coord_sel = 1'b1;
        cmd_o.div_step  = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN_Y;
        end
      end
      ST_FIN_Y: begin
        cmd_o.coord_sel = 1'b1;
        cmd_o.map_store = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        if (status_i.iter_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/mep_datapath.sv
module mep_datapath #(
  parameter int unsigned IMAGE_WIDTH  = 1280,
  parameter int unsigned IMAGE_HEIGHT = 960
) (
  input  logic                 clk_i,
  input  mep_pkg::dp_cmd_t     cmd_i,
  output mep_pkg::dp_status_t  status_o,
  input  mep_pkg::cfg_t        cfg_i,
  input  mep_pkg::pixel_in_t   in_data_i,
  output mep_pkg::pixel_out_t  out_data_o
);
  import mep_pkg::*;

  localparam int unsigned DivMax = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int unsigned DivW   = $clog2(DivMax + 1);
  localparam logic [DivW-1:0] WidthDiv  = DivW'(IMAGE_WIDTH);
  localparam logic [DivW-1:0] HeightDiv = DivW'(IMAGE_HEIGHT);

  // Reciprocal floor(2^MAGW / d), d of 16 or more
  localparam int unsigned RcpW = MAGW - 3;
  localparam int unsigned AccW = MAGW + RcpW;
  localparam int unsigned ChW  = 15;   // dividend chunk per multiply step
  localparam logic [RcpW-1:0] WidthRcp  = RcpW'((64'd1 << MAGW) / IMAGE_WIDTH);
  localparam logic [RcpW-1:0] HeightRcp = RcpW'((64'd1 << MAGW) / IMAGE_HEIGHT);

  // Divide steps: three multiply-accumulate chunks, quotient estimate, correction
  localparam int unsigned CntW = 3;
  localparam logic [CntW-1:0] StepHi   = CntW'(0);
  localparam logic [CntW-1:0] StepMid  = CntW'(1);
  localparam logic [CntW-1:0] StepQuot = CntW'(3);
  localparam logic [CntW-1:0] CntLast  = CntW'(4);

  // Pixel and point registers
  logic [XW-1:0]          px_q;
  logic [YW-1:0]          py_q;
  logic signed [QW-1:0]   cr_q, ci_q;
  logic signed [QW-1:0]   zr_q, zi_q;
  logic [ITW-1:0]         it_q;

  // Reciprocal divider
  logic [MAGW-1:0]        mag_q;
  logic                   neg_q;
  logic [AccW-1:0]        acc_q;
  logic [MAGW-1:0]        quo_q;
  logic [DivW:0]          rem_q;
  logic [CntW-1:0]        cnt_q;

  // Product registers
  logic signed [PRODW-1:0] rr_q, ii_q, ri_q;

  pixel_out_t             out_q;

  // ---- coordinate mapping ----
  logic [XW-1:0]          idx;
  logic signed [QW-1:0]   lo, hi;
  logic [DivW-1:0]        divisor;
  logic [RcpW-1:0]        rcp;
  logic signed [QW:0]     span;
  logic signed [SUMW-1:0] prod;
  logic signed [SUMW-1:0] prod_abs;

  assign idx     = cmd_i.coord_sel ? {1'b0, py_q} : px_q;
  assign lo      = cmd_i.coord_sel ? cfg_i.top_edge : cfg_i.left_edge;
  assign hi      = cmd_i.coord_sel ? cfg_i.bottom_edge : cfg_i.right_edge;
  assign divisor = cmd_i.coord_sel ? HeightDiv : WidthDiv;
  assign rcp     = cmd_i.coord_sel ? HeightRcp : WidthRcp;
  assign span    = $signed({hi[QW-1], hi}) - $signed({lo[QW-1], lo});
  assign prod    = $signed({1'b0, idx}) * span;
  assign prod_abs = prod[SUMW-1] ? -prod : prod;

  // |prod| * rcp built top chunk first; estimate is the quotient or one short
  logic [ChW-1:0]        chunk;
  logic [ChW+RcpW-1:0]   part_prod;
  logic [AccW-1:0]       acc_next;
  logic [MAGW-1:0]       q_est;
  logic [2*DivW:0]       qd_prod;

  always_comb begin
    case (cnt_q)
      StepHi:  chunk = {{(3*ChW-MAGW){1'b0}}, mag_q[MAGW-1:2*ChW]};
      StepMid: chunk = mag_q[2*ChW-1:ChW];
      default: chunk = mag_q[ChW-1:0];
    endcase
  end

  assign part_prod = chunk * rcp;
  assign acc_next  = {acc_q[AccW-ChW-1:0], {ChW{1'b0}}}
                   + {{(AccW-ChW-RcpW){1'b0}}, part_prod};
  assign q_est     = {{(MAGW-RcpW){1'b0}}, acc_q[AccW-1:MAGW]};
  // remainder is below 2*d, so the low bits are enough
  assign qd_prod   = q_est[DivW:0] * divisor;

  // signed quotient, offset by the edge
  logic signed [MAGW:0]   quot;
  logic signed [SUMW-1:0] coord_sum;
  logic signed [QW-1:0]   coord;

  assign quot      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign coord_sum = $signed({{(SUMW-QW){lo[QW-1]}}, lo})
                   + $signed({{(SUMW-MAGW-1){quot[MAGW]}}, quot});
  assign coord     = sat_q(coord_sum);

  // ---- iteration ----
  logic [PRODW:0]          sq_sum;
  logic                    escaped;
  logic signed [35:0]      rr_s, ii_s;
  logic signed [36:0]      ri_s;
  logic signed [SUMW-1:0]  zr_sum, zi_sum;
  logic                    at_limit;

  assign sq_sum   = {1'b0, rr_q} + {1'b0, ii_q};
  assign escaped  = (sq_sum >= {1'b0, FOUR_Q56});
  assign at_limit = (it_q == cfg_i.iteration_limit);

  // floor shifts: arithmetic part-selects
  assign rr_s = rr_q[PRODW-1:QFRAC];
  assign ii_s = ii_q[PRODW-1:QFRAC];
  assign ri_s = ri_q[PRODW-1:QFRAC-1];

  assign zr_sum = $signed({{(SUMW-36){rr_s[35]}}, rr_s})
                - $signed({{(SUMW-36){ii_s[35]}}, ii_s})
                + $signed({{(SUMW-QW){cr_q[QW-1]}}, cr_q});
  assign zi_sum = $signed({{(SUMW-37){ri_s[36]}}, ri_s})
                + $signed({{(SUMW-QW){ci_q[QW-1]}}, ci_q});

  assign status_o.div_last  = (cnt_q == CntLast);
  assign status_o.iter_done = escaped || at_limit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pixel) begin
      px_q <= in_data_i.pixel_x;
      py_q <= in_data_i.pixel_y;
      zr_q <= '0;
      zi_q <= '0;
      it_q <= '0;
    end

    if (cmd_i.map_load) begin
      mag_q <= prod_abs[MAGW-1:0];
      neg_q <= prod[SUMW-1];
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
      case (cnt_q)
        StepQuot: begin
          quo_q <= q_est;
          rem_q <= mag_q[DivW:0] - qd_prod[DivW:0];
        end
        CntLast: begin
          if (rem_q >= {1'b0, divisor}) begin
            quo_q <= quo_q + 1'b1;
          end
        end
        default: begin
          acc_q <= acc_next;
        end
      endcase
    end

    if (cmd_i.map_store) begin
      if (cmd_i.coord_sel) begin
        ci_q <= coord;
      end else begin
        cr_q <= coord;
      end
    end

    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end

    if (cmd_i.update) begin
      zr_q <= sat_q(zr_sum);
      zi_q <= sat_q(zi_sum);
      it_q <= it_q + 1'b1;
    end

    if (cmd_i.out_load) begin
      out_q.out_x           <= px_q;
      out_q.out_y           <= py_q;
      out_q.pixel_colour    <= at_limit ? cfg_i.member_colour : '0;
      out_q.iteration_count <= it_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/mandelbrot_escape_pixel_core.sv
// Mandelbrot escape-time pixel core, one pixel in flight.
// Per pixel: a reciprocal divide per axis for the coordinate map (multiply-accumulate
// chunks, quotient estimate, correction), then a multiply and an update step per
// iteration until escape or limit, with one final escape/limit check before the result
// is parked. A new pixel is taken while the previous result waits in the output
// register. Reset (rst_ni low, async) empties the pipe and loads the default view.
module mandelbrot_escape_pixel_core #(
  parameter int unsigned IMAGE_WIDTH  = 1280,
  parameter int unsigned IMAGE_HEIGHT = 960
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  mep_pkg::pixel_in_t                 in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output mep_pkg::pixel_out_t                out_data_o,
  // register write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mep_pkg::CFGIW-1:0]          cfg_index_i,
  input  logic [mep_pkg::CFGDW-1:0]          cfg_data_i
);
  import mep_pkg::*;

  // View registers. Writes land any time; they are only
  // expected while the core is idle, so no shadowing is done.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge       <= LEFT_RST;
      cfg_q.right_edge      <= RIGHT_RST;
      cfg_q.top_edge        <= TOP_RST;
      cfg_q.bottom_edge     <= BOTTOM_RST;
      cfg_q.member_colour   <= COLOUR_RST;
      cfg_q.iteration_limit <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LEFT:   cfg_q.left_edge       <= cfg_data_i;
        CFG_RIGHT:  cfg_q.right_edge      <= cfg_data_i;
        CFG_TOP:    cfg_q.top_edge        <= cfg_data_i;
        CFG_BOTTOM: cfg_q.bottom_edge     <= cfg_data_i;
        CFG_COLOUR: cfg_q.member_colour   <= cfg_data_i[COLW-1:0];
        CFG_LIMIT:  cfg_q.iteration_limit <= cfg_data_i[ITW-1:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Controller sequences: map x, map y, then multiply/update until
  // escape or limit, then park the result in the output register.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  // Datapath: 11x33 map multiply + reciprocal divider shared by both axes,
  // three 32x32 multipliers (two squares, one cross product), Q3.28 saturation on every write-back.
  mep_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
